FILE: src/qtk_pkg.sv
// Shared types, constants and bit-interleave helpers for the quadtree tile-key unit.
// No dependencies; every other source file imports this package.
package qtk_pkg;

	localparam int FACE_W     = 3;
	localparam int LEVEL_W    = 5;
	localparam int COORD_W    = 28;
	localparam int MORTON_W   = 2 * COORD_W;
	localparam int KEY_W      = 64;
	localparam int FACE_LSB   = 61;
	localparam int LEVEL_LSB  = 56;

	localparam logic [FACE_W-1:0] FACE_LIMIT  = 3'd5;
	localparam logic [5:0]        LEVEL_LIMIT = 6'd28;

	typedef enum logic [1:0] {
		KIND_ENCODE   = 2'd0,
		KIND_CHECK    = 2'd1,
		KIND_PARENT   = 2'd2,
		KIND_CHILDREN = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FACE     = 3'd1,
		ST_LEVEL    = 3'd2,
		ST_COORD    = 3'd3,
		ST_UNUSED   = 3'd4,
		ST_NOPARENT = 3'd5,
		ST_NOCHILD  = 3'd6
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         face;
		logic [5:0]         tile_level;
		logic [31:0]        x_coord;
		logic [31:0]        y_coord;
		logic [KEY_W-1:0]   key_in;
	} in_word_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key_out;
		logic [FACE_W-1:0]  face_out;
		logic [LEVEL_W-1:0] level_out;
		logic [COORD_W-1:0] x_out;
		logic [COORD_W-1:0] y_out;
		status_t            status;
		logic               last;
	} out_word_t;

	// x bit i -> bit 2i, y bit i -> bit 2i+1
	function automatic logic [MORTON_W-1:0] spread_bits(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		logic [MORTON_W-1:0] m;
		m = '0;
		for (int b = 0; b < COORD_W; b++) begin
			m[2*b]   = x[b];
			m[2*b+1] = y[b];
		end
		return m;
	endfunction

	function automatic logic [COORD_W-1:0] gather_bits(input logic [MORTON_W-1:0] m,
			input logic odd);
		logic [COORD_W-1:0] r;
		r = '0;
		for (int b = 0; b < COORD_W; b++)
			r[b] = odd ? m[2*b+1] : m[2*b];
		return r;
	endfunction

endpackage

FILE: src/qtk_calc.sv
// Combinational tile-key operation: encode, check, parent, one child per sub index.
// Depends on qtk_pkg.
module qtk_calc import qtk_pkg::*; (
	input  in_word_t  item,
	input  logic [1:0] sub,
	output out_word_t res
);

	logic [MORTON_W-1:0] m;
	logic [FACE_W-1:0]   kf;
	logic [LEVEL_W-1:0]  kl;
	logic [KEY_W-1:0]    key;
	status_t             err;
	logic                child_last;

	assign m  = item.key_in[MORTON_W-1:0];
	assign kf = item.key_in[KEY_W-1:FACE_LSB];
	assign kl = item.key_in[FACE_LSB-1:LEVEL_LSB];

	always_comb begin
		key        = '0;
		err        = ST_OK;
		child_last = 1'b1;
		case (item.kind)
			KIND_ENCODE: begin
				if (item.face > FACE_LIMIT)
					err = ST_FACE;
				else if (item.tile_level > LEVEL_LIMIT)
					err = ST_LEVEL;
				else if ((item.x_coord >> item.tile_level) != 32'd0 ||
						(item.y_coord >> item.tile_level) != 32'd0)
					err = ST_COORD;
				else
					key = {item.face, item.tile_level[LEVEL_W-1:0],
						spread_bits(item.x_coord[COORD_W-1:0], item.y_coord[COORD_W-1:0])};
			end
			default: begin
				// key validation shared by check, parent and children
				if (kf > FACE_LIMIT)
					err = ST_FACE;
				else if ({1'b0, kl} > LEVEL_LIMIT)
					err = ST_LEVEL;
				else if ((m >> {kl, 1'b0}) != '0)
					err = ST_UNUSED;
				else begin
					case (item.kind)
						KIND_PARENT: begin
							if (kl == '0)
								err = ST_NOPARENT;
							else
								key = {kf, kl - 5'd1, 2'b00, m[MORTON_W-1:2]};
						end
						KIND_CHILDREN: begin
							if ({1'b0, kl} == LEVEL_LIMIT)
								err = ST_NOCHILD;
							else begin
								key = {kf, kl + 5'd1, m[MORTON_W-3:0], sub};
								child_last = (sub == 2'd3);
							end
						end
						default: key = item.key_in;
					endcase
				end
			end
		endcase
	end

	always_comb begin
		res = '0;
		res.status = err;
		res.last = 1'b1;
		if (err == ST_OK) begin
			res.key_out   = key;
			res.face_out  = key[KEY_W-1:FACE_LSB];
			res.level_out = key[FACE_LSB-1:LEVEL_LSB];
			res.x_out     = gather_bits(key[MORTON_W-1:0], 1'b0);
			res.y_out     = gather_bits(key[MORTON_W-1:0], 1'b1);
			res.last      = child_last;
		end
	end

endmodule

FILE: src/quadtree_tile_key_unit_core.sv
// Top level of the quadtree tile-key unit: input register, operation logic, result register.
// Depends on qtk_pkg and qtk_calc.
//
// Usage:
//   in_valid/in_ready/in_data carries one request word (kind, face, tile_level,
//   x_coord, y_coord, key_in). out_valid/out_ready/out_data returns result words
//   (key, decoded face/level/x/y, status, last).
//   Path: an accepted word goes from the input register, through the operation
//   logic, into the result register, which presents its first result word.
//   Throughput: one word per cycle while out_ready is high. A successful children
//   request holds the input register for four words (keys in Morton order 0..3, last on
//   the fourth); every other request, and every error, gives one result word.
//   in_ready rises again in the cycle the last result of the held word moves
//   into the result register, so requests follow back to back.
//   Stall: while out_ready is low the result register holds its word, the
//   input register holds its word, and in_ready stays low once both are full.
//   Reset (arst_n low) empties both registers; no words are lost or invented
//   after reset is released.
module quadtree_tile_key_unit_core import qtk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic      valid_s1;
	in_word_t  item_s1;
	logic [1:0] sub_s1;
	out_word_t res;
	logic      emit;
	logic      out_valid_q;
	out_word_t out_q;

	qtk_calc u_calc (
		.item (item_s1),
		.sub  (sub_s1),
		.res  (res)
	);

	assign emit     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || (emit && res.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sub_s1   <= '0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
			sub_s1   <= '0;
		end else if (emit) begin
			valid_s1 <= !res.last;
			sub_s1   <= sub_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || out_ready)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/qtk_checker.sv
// Port-level checks for the quadtree tile-key unit, bound to the top level.
// Depends on qtk_pkg and quadtree_tile_key_unit_core.
module qtk_checker import qtk_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last && out_data.key_out == '0)
		else $error("error word not final or carries a key");

	a_fields_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK |->
			out_data.face_out == out_data.key_out[KEY_W-1:FACE_LSB] &&
			out_data.level_out == out_data.key_out[FACE_LSB-1:LEVEL_LSB])
		else $error("decoded face or level disagrees with key");

	// a non-final word is a child key; the next one is its sibling at index + 1
	a_child_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=>
			out_valid && out_data.key_out[1:0] == $past(out_data.key_out[1:0]) + 2'd1)
		else $error("child keys out of order");

endmodule

bind quadtree_tile_key_unit_core qtk_checker u_qtk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
